// ----- rtl/interval_booking_table_macros.svh -----
// Assertion helpers used by the top-level RTL file.
`ifndef INTERVAL_BOOKING_TABLE_MACROS_SVH
`define INTERVAL_BOOKING_TABLE_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define IBT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while in reset.
`define IBT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/ibt_pkg.sv -----
package ibt_pkg;

  // Default table depth
  localparam int IBT_MAX_BOOKINGS = 1024;

  // Request and result field widths
  localparam int TIME_W = 32;
  localparam int HELD_W = 11;

  // Result codes
  typedef enum logic [1:0] {
    OUT_BOOKED  = 2'd0,
    OUT_OVERLAP = 2'd1,
    OUT_FULL    = 2'd2,
    OUT_INVALID = 2'd3
  } ibt_outcome_t;

  // Tag that travels with a table read
  typedef struct packed {
    logic vld;
    logic last;
  } ibt_tag_t;

  // Registered result of the compare unit
  typedef struct packed {
    logic vld;
    logic last;
    logic clash;
  } ibt_res_t;

endpackage

// ----- rtl/ibt_store.sv -----
module ibt_store
  import ibt_pkg::*;
#(
  parameter int MAX_BOOKINGS = IBT_MAX_BOOKINGS,
  parameter int IDX_W        = $clog2(MAX_BOOKINGS)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              flush,
  input  logic              wr_en,
  input  logic [IDX_W-1:0]  wr_addr,
  input  logic [TIME_W-1:0] wr_start,
  input  logic [TIME_W-1:0] wr_end,
  input  ibt_tag_t          rd_req,
  input  logic [IDX_W-1:0]  rd_addr,
  output logic [TIME_W-1:0] rd_start_r,
  output logic [TIME_W-1:0] rd_end_r,
  output ibt_tag_t          rd_tag_r
);

  // One entry holds {end, start}
  logic [2*TIME_W-1:0] mem [MAX_BOOKINGS];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_end, wr_start};
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_req.vld) begin
      {rd_end_r, rd_start_r} <= mem[rd_addr];
    end
  end

  // Read tag follows the data
  always_ff @(posedge clk) begin
    if (!rst_n || flush) begin
      rd_tag_r <= '0;
    end else begin
      rd_tag_r <= rd_req;
    end
  end

endmodule

// ----- rtl/ibt_cmp.sv -----
module ibt_cmp
  import ibt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              flush,
  input  ibt_tag_t          tag,
  input  logic [TIME_W-1:0] stored_start,
  input  logic [TIME_W-1:0] stored_end,
  input  logic [TIME_W-1:0] req_start,
  input  logic [TIME_W-1:0] req_end,
  output ibt_res_t          res_r
);

  ibt_res_t res_nxt;

  // Stored entry is clear when it ends before the request starts
  // or starts after the request ends.
  always_comb begin
    res_nxt.vld   = tag.vld;
    res_nxt.last  = tag.last;
    res_nxt.clash = !((stored_end <= req_start) || (req_end <= stored_start));
  end

  always_ff @(posedge clk) begin
    if (!rst_n || flush) begin
      res_r <= '0;
    end else begin
      res_r <= res_nxt;
    end
  end

endmodule

// ----- rtl/interval_booking_table.sv -----
// Interval booking table. Each request on the in_ channel asks to book the
// half-open interval [start_time, end_time); exactly one result follows on
// the out_ channel with the outcome (booked, overlap, table full, invalid)
// and the number of intervals held afterwards. Accepted intervals are kept
// in a single-port-read table of MAX_BOOKINGS entries and every valid
// request is checked against the N entries already held, one entry per
// cycle through the table read port and one shared compare unit. The scan
// stops early when a clash is found, and an invalid interval or an empty
// table skips it. in_tready is high only while no request is in work; a
// finished result waits in the output register without holding up the
// next request. No clearing pass is needed after reset.
module interval_booking_table
  import ibt_pkg::*;
#(
  parameter int MAX_BOOKINGS = IBT_MAX_BOOKINGS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] start_time, [63:32] end_time
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [1:0] outcome, [12:2] bookings_held, [15:13] zero
);

`include "interval_booking_table_macros.svh"

  localparam int IDX_W = (MAX_BOOKINGS > 1) ? $clog2(MAX_BOOKINGS) : 1;
  localparam int CNT_W = $clog2(MAX_BOOKINGS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BOOKINGS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  state_t            state_r, state_nxt;
  logic [TIME_W-1:0] lo_r, lo_nxt;
  logic [TIME_W-1:0] hi_r, hi_nxt;
  ibt_outcome_t      code_r, code_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              issuing_r, issuing_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              out_tvalid_r, out_tvalid_nxt;
  ibt_outcome_t      out_code_r, out_code_nxt;
  logic [HELD_W-1:0] out_held_r, out_held_nxt;

  logic              in_fire;
  logic              done_fire;
  ibt_outcome_t      final_code;
  logic [TIME_W-1:0] req_start;
  logic [TIME_W-1:0] req_end;
  ibt_tag_t          rd_req;
  ibt_tag_t          rd_tag;
  logic [TIME_W-1:0] rd_start;
  logic [TIME_W-1:0] rd_end;
  ibt_res_t          cmp_res;
  logic              wr_en;

  assign req_start = in_tdata[31:0];
  assign req_end   = in_tdata[63:32];
  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign done_fire = (state_r == S_DONE) && (!out_tvalid_r || out_tready);

  // Full only matters for a request that is otherwise bookable
  assign final_code = ((code_r == OUT_BOOKED) && (count_r == CNT_MAX)) ? OUT_FULL : code_r;
  assign wr_en      = done_fire && (final_code == OUT_BOOKED);

  // Table read requests during the scan
  always_comb begin
    rd_req.vld  = (state_r == S_SCAN) && issuing_r;
    rd_req.last = (CNT_W'(idx_r) == (count_r - CNT_W'(1)));
  end

  ibt_store #(
    .MAX_BOOKINGS(MAX_BOOKINGS),
    .IDX_W       (IDX_W)
  ) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .flush     (in_fire),
    .wr_en     (wr_en),
    .wr_addr   (count_r[IDX_W-1:0]),
    .wr_start  (lo_r),
    .wr_end    (hi_r),
    .rd_req    (rd_req),
    .rd_addr   (idx_r),
    .rd_start_r(rd_start),
    .rd_end_r  (rd_end),
    .rd_tag_r  (rd_tag)
  );

  ibt_cmp u_cmp (
    .clk         (clk),
    .rst_n       (rst_n),
    .flush       (in_fire),
    .tag         (rd_tag),
    .stored_start(rd_start),
    .stored_end  (rd_end),
    .req_start   (lo_r),
    .req_end     (hi_r),
    .res_r       (cmp_res)
  );

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    code_nxt       = code_r;
    idx_nxt        = idx_r;
    issuing_nxt    = issuing_r;
    count_nxt      = count_r;
    out_tvalid_nxt = out_tvalid_r;
    out_code_nxt   = out_code_r;
    out_held_nxt   = out_held_r;

    // Output register drains independently
    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          lo_nxt      = req_start;
          hi_nxt      = req_end;
          idx_nxt     = '0;
          issuing_nxt = 1'b1;
          if (req_end <= req_start) begin
            code_nxt  = OUT_INVALID;
            state_nxt = S_DONE;
          end else if (count_r == '0) begin
            code_nxt  = OUT_BOOKED;
            state_nxt = S_DONE;
          end else begin
            code_nxt  = OUT_BOOKED;
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // Step the read address until the last held entry is issued
        if (issuing_r) begin
          if (rd_req.last) begin
            issuing_nxt = 1'b0;
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
        if (cmp_res.vld && cmp_res.clash) begin
          code_nxt  = OUT_OVERLAP;
          state_nxt = S_DONE;
        end else if (cmp_res.vld && cmp_res.last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (done_fire) begin
          if (final_code == OUT_BOOKED) begin
            count_nxt = count_r + CNT_W'(1);
          end
          out_tvalid_nxt = 1'b1;
          out_code_nxt   = final_code;
          out_held_nxt   = HELD_W'(count_nxt);
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      issuing_r    <= 1'b0;
      count_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      issuing_r    <= issuing_nxt;
      count_r      <= count_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    code_r     <= code_nxt;
    idx_r      <= idx_nxt;
    out_code_r <= out_code_nxt;
    out_held_r <= out_held_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {3'b000, out_held_r, out_code_r};

  // Checks
  `IBT_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_r <= CNT_MAX,
    "entry count above table depth")
  `IBT_ASSERT_NEXT(a_accept_busy, clk, rst_n, in_fire, state_r != S_IDLE,
    "accepted request did not start work")
  `IBT_ASSERT_NEXT(a_book_count, clk, rst_n, wr_en, count_r == $past(count_r) + CNT_W'(1),
    "booking did not advance entry count")
  `IBT_ASSERT_IMPL(a_read_in_scan, clk, rst_n, rd_req.vld,
    (state_r == S_SCAN) && (CNT_W'(idx_r) < count_r),
    "table read outside held entries")

endmodule
